@@ hw/rtl/b64u_pkg.sv @@
// Package with the shared types, status codes and the character map of the base64url decoder.
`default_nettype none

package b64u_pkg;

  typedef logic [7:0] char_t;
  typedef logic [5:0] sextet_t;
  typedef logic [1:0] status_t;

  localparam status_t STATUS_OK       = 2'd0;
  localparam status_t STATUS_BAD_CHAR = 2'd1;
  localparam status_t STATUS_BAD_LEN  = 2'd2;
  localparam status_t STATUS_UNUSED   = 2'd3;

  typedef struct packed {
    logic    ok;
    sextet_t value;
  } sextet_map_t;

  // Maps one character of the URL-safe alphabet to its six-bit value.
  function automatic sextet_map_t map_char(input char_t c);
    sextet_map_t m;
    m.ok    = 1'b1;
    m.value = '0;
    if (c >= 8'h41 && c <= 8'h5a) begin
      m.value = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      m.value = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      m.value = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2d) begin
      m.value = 6'd62;
    end else if (c == 8'h5f) begin
      m.value = 6'd63;
    end else begin
      m.ok = 1'b0;
    end
    return m;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/b64u_if.sv @@
// Channel interfaces of the base64url decoder: character requests in, decoded results out.
`default_nettype none

interface b64u_in_if;
  import b64u_pkg::*;
  logic  valid;
  logic  ready;
  char_t char_code;
  logic  end_of_text;

  modport source (output valid, output char_code, output end_of_text, input ready);
  modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

interface b64u_out_if;
  import b64u_pkg::*;
  logic    valid;
  logic    ready;
  char_t   data_byte;
  logic    byte_valid;
  logic    done_res;
  status_t status;

  modport source (output valid, output data_byte, output byte_valid, output done_res,
                  output status, input ready);
  modport sink   (input valid, input data_byte, input byte_valid, input done_res,
                  input status, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/strict_base64url_decoder.sv @@
// Top level of the strict unpadded base64url decoder.
//
// Usage: each request on in_ch carries one ASCII character of a base64url
// text, with end_of_text set on the final character. Every request produces
// exactly one result on out_ch. A result carries a decoded byte whenever the
// character completed eight bits (byte_valid set), and the result for the
// final character also carries done_res and the status of the whole text.
// Each request passes through the input register and then the result
// register, and its result is shown from the result register.
// Throughput is one character per cycle while the receiver does not stall;
// the character map and the shift between the two registers are
// combinational, so both sides may stream.
// When the receiver stalls, the result register holds its request and the
// input register still takes one more character; the input side then stalls
// until the result moves on. Nothing is lost or repeated.
// Reset (rst_n low, synchronous) empties both registers and clears the
// leftover bits, the position within the four-character group and the
// sticky bad-character flag. The same state clears after every final
// character, so the next text starts fresh.
`default_nettype none

module strict_base64url_decoder (
  input  wire logic   clk,
  input  wire logic   rst_n,
  b64u_in_if.sink     in_ch,
  b64u_out_if.source  out_ch
);
  import b64u_pkg::*;

  // Input register.
  logic        s1_valid_r;
  char_t       s1_char_r;
  logic        s1_last_r;

  // Result register.
  logic        out_valid_r;
  char_t       out_byte_r;
  logic        out_byte_valid_r;
  logic        out_done_r;
  status_t     out_status_r;

  // Decoder state, updated when a character moves into the result register.
  logic [5:0]  leftover_r;
  logic [5:0]  leftover_nxt;
  logic [1:0]  position_r;
  logic [1:0]  position_nxt;
  logic        bad_seen_r;
  logic        bad_seen_nxt;

  sextet_map_t map;
  sextet_t     sextet;
  logic [1:0]  position_inc;
  char_t       byte_nxt;
  logic        byte_valid_nxt;
  status_t     status_nxt;
  logic        advance;
  logic        in_take;

  // The input register moves forward when the result register is empty or
  // its request is being taken this cycle.
  assign advance     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;
  assign in_take     = in_ch.valid && in_ch.ready;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.data_byte  = out_byte_r;
  assign out_ch.byte_valid = out_byte_valid_r;
  assign out_ch.done_res   = out_done_r;
  assign out_ch.status     = out_status_r;

  // A bad character still counts toward the length, with the value zero.
  assign map          = map_char(s1_char_r);
  assign sextet       = map.ok ? map.value : '0;
  assign bad_seen_nxt = bad_seen_r || !map.ok;
  assign position_inc = position_r + 2'd1;

  always_comb begin
    byte_nxt       = '0;
    byte_valid_nxt = 1'b0;
    leftover_nxt   = '0;
    unique case (position_r)
      2'd0: begin
        leftover_nxt = sextet;
      end
      2'd1: begin
        byte_nxt       = {leftover_r, sextet[5:4]};
        byte_valid_nxt = 1'b1;
        leftover_nxt   = {2'b00, sextet[3:0]};
      end
      2'd2: begin
        byte_nxt       = {leftover_r[3:0], sextet[5:2]};
        byte_valid_nxt = 1'b1;
        leftover_nxt   = {4'b0000, sextet[1:0]};
      end
      2'd3: begin
        byte_nxt       = {leftover_r[1:0], sextet};
        byte_valid_nxt = 1'b1;
        leftover_nxt   = '0;
      end
      default: begin
        leftover_nxt = '0;
      end
    endcase
  end

  // Status priority: bad character, then a group left with one character,
  // then leftover bits that are not zero.
  always_comb begin
    status_nxt   = STATUS_OK;
    position_nxt = position_inc;
    if (s1_last_r) begin
      priority if (bad_seen_nxt) begin
        status_nxt = STATUS_BAD_CHAR;
      end else if (position_inc == 2'd1) begin
        status_nxt = STATUS_BAD_LEN;
      end else if (position_inc != 2'd0 && leftover_nxt != '0) begin
        status_nxt = STATUS_UNUSED;
      end else begin
        status_nxt = STATUS_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      leftover_r  <= '0;
      position_r  <= '0;
      bad_seen_r  <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end

      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      if (advance) begin
        if (s1_last_r) begin
          leftover_r <= '0;
          position_r <= '0;
          bad_seen_r <= 1'b0;
        end else begin
          leftover_r <= leftover_nxt;
          position_r <= position_nxt;
          bad_seen_r <= bad_seen_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_char_r <= in_ch.char_code;
      s1_last_r <= in_ch.end_of_text;
    end
    if (advance) begin
      out_byte_r       <= byte_nxt;
      out_byte_valid_r <= byte_valid_nxt;
      out_done_r       <= s1_last_r;
      out_status_r     <= status_nxt;
    end
  end

endmodule

`default_nettype wire
